/* rtl/cfp_pkg.sv */
// Shared types and constants of the control frame parser.
package cfp_pkg;

    // Received characters with a meaning of their own
    localparam logic [7:0] CH_START  = 8'h21;  // '!'
    localparam logic [7:0] CH_QUERY  = 8'h3F;  // '?'
    localparam logic [7:0] CH_DASH   = 8'h2D;  // '-'
    localparam logic [7:0] CH_BUTTON = 8'h42;  // 'B'
    localparam logic [7:0] CH_ENC    = 8'h45;  // 'E'
    localparam logic [7:0] CH_CONFIG = 8'h43;  // 'C'
    localparam logic [7:0] CH_ZERO   = 8'd48;  // '0'
    localparam logic [7:0] CH_NINE   = 8'd57;  // '9'

    // Token kinds
    localparam logic [1:0] TOK_OTHER  = 2'd0;
    localparam logic [1:0] TOK_BUTTON = 2'd1;
    localparam logic [1:0] TOK_ENC    = 2'd2;
    localparam logic [1:0] TOK_CONFIG = 2'd3;

    // Frame positions: 1 sign, 2..4 angle digits, 5 body
    localparam logic [2:0] POS_IDLE  = 3'd0;
    localparam logic [2:0] POS_SIGN  = 3'd1;
    localparam logic [2:0] POS_HUND  = 3'd2;
    localparam logic [2:0] POS_TENS  = 3'd3;
    localparam logic [2:0] POS_ONES  = 3'd4;
    localparam logic [2:0] POS_BODY  = 3'd5;

    localparam logic [3:0] NIB_BAD   = 4'hF;
    localparam logic [2:0] LEN_MAX   = 3'd7;

    // Fixed result widths
    localparam int ANGLE_W   = 11;
    localparam int ACC_W     = 10;
    localparam int BTN_OUT_W = 15;
    localparam int ENC_W     = 10;
    localparam int ENC_OUTS  = 6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  length;
        logic [15:0] digits;
    } t_token;

    typedef struct packed {
        logic             btn_en;
        logic [6:0]       btn_idx;
        logic             enc_en;
        logic [3:0]       enc_idx;
        logic [ENC_W-1:0] enc_val;
        logic             cfg_en;
    } t_close_act;

endpackage

/* rtl/cfp_token_close.sv */
// Decode of a closed token into a button set, encoder write or config flag.
module cfp_token_close
    import cfp_pkg::*;
#(
    parameter int NUM_BUTTONS  = 15,
    parameter int NUM_ENCODERS = 6
) (
    input  t_token     i_token,
    output t_close_act o_act
);

    logic [3:0] nib0, nib1, nib2, nib3;
    logic       dig0, dig1, dig2, dig3;
    logic       btn_ok;
    logic [6:0] btn_idx;

    assign nib0 = i_token.digits[3:0];
    assign nib1 = i_token.digits[7:4];
    assign nib2 = i_token.digits[11:8];
    assign nib3 = i_token.digits[15:12];
    assign dig0 = (nib0 <= 4'd9);
    assign dig1 = (nib1 <= 4'd9);
    assign dig2 = (nib2 <= 4'd9);
    assign dig3 = (nib3 <= 4'd9);

    always_comb begin
        // exactly three chars means a two-digit index
        if (i_token.length == 3'd3) begin
            btn_ok  = dig0 && dig1;
            btn_idx = 7'(nib0) * 7'd10 + 7'(nib1);
        end else begin
            btn_ok  = (i_token.length >= 3'd2) && dig0;
            btn_idx = 7'(nib0);
        end
    end

    always_comb begin
        o_act.btn_en  = (i_token.kind == TOK_BUTTON) && btn_ok
                        && (32'(btn_idx) < NUM_BUTTONS);
        o_act.btn_idx = btn_idx;
        o_act.enc_en  = (i_token.kind == TOK_ENC) && (i_token.length >= 3'd5)
                        && dig0 && dig1 && dig2 && dig3
                        && (32'(nib0) < NUM_ENCODERS);
        o_act.enc_idx = nib0;
        o_act.enc_val = ENC_W'(nib1) * ENC_W'(100) + ENC_W'(nib2) * ENC_W'(10)
                        + ENC_W'(nib3);
        o_act.cfg_en  = (i_token.kind == TOK_CONFIG) && (i_token.length >= 3'd1);
    end

endmodule

/* rtl/control_frame_parser.sv */
// Control frame parser: byte stream in, one frame summary out per '?' that closes a frame.
//
// Input channel: i_rx_valid / o_rx_ready carry one received byte per item.
// Output channel: o_res_valid / i_res_ready carry one result item (angle,
// button mask, six encoder values, sticky config flag) for every '?' that
// closes an open frame; all other bytes give no result.
// Throughput: one byte per cycle while o_rx_ready is high. Each byte updates
// the frame state in the cycle it is accepted; a '?' loads the result register
// at that edge, so the result is valid in the cycle after the byte is accepted.
// The result register is the only buffer: while it holds an item that the
// receiver has not taken, o_rx_ready stays low; as soon as the receiver
// takes it (same cycle is fine) the next byte is accepted.
// Reset (i_rst_n low, synchronous) closes any frame, clears buttons,
// encoders, angle and the sticky config flag, and empties the result
// register.
// Frames: '!' opens or restarts a frame, then sign, three angle digits,
// then dash-separated B, E and C tokens; the token still open at '?' is
// dropped.
module control_frame_parser
    import cfp_pkg::*;
#(
    parameter int NUM_BUTTONS  = 15,
    parameter int NUM_ENCODERS = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rx_valid,
    output logic                       o_rx_ready,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic signed [ANGLE_W-1:0]  o_angle,
    output logic [BTN_OUT_W-1:0]       o_buttons,
    output logic [ENC_W-1:0]           o_encoder_0,
    output logic [ENC_W-1:0]           o_encoder_1,
    output logic [ENC_W-1:0]           o_encoder_2,
    output logic [ENC_W-1:0]           o_encoder_3,
    output logic [ENC_W-1:0]           o_encoder_4,
    output logic [ENC_W-1:0]           o_encoder_5,
    output logic                       o_config_seen
);

    // frame state
    logic                   r_in_frame,   n_in_frame;
    logic [2:0]             r_position,   n_position;
    logic                   r_negative,   n_negative;
    logic [ACC_W-1:0]       r_angle_acc,  n_angle_acc;
    logic                   r_tok_open,   n_tok_open;
    t_token                 r_token,      n_token;
    logic [NUM_BUTTONS-1:0] r_btn_mask,   n_btn_mask;
    logic [ENC_W-1:0]       r_enc [NUM_ENCODERS];
    logic [ENC_W-1:0]       n_enc [NUM_ENCODERS];
    logic                   r_cfg_flag,   n_cfg_flag;

    // result register
    logic                   r_res_valid;
    logic [ANGLE_W-1:0]     r_res_angle;
    logic [BTN_OUT_W-1:0]   r_res_buttons;
    logic [ENC_W-1:0]       r_res_enc [ENC_OUTS];
    logic                   r_res_cfg;

    logic                   rx_acc;
    logic                   res_load;
    logic [3:0]             digit;
    logic                   is_digit;
    logic [ACC_W-1:0]       digit_weighted;
    logic [ANGLE_W-1:0]     angle_signed;
    logic [BTN_OUT_W-1:0]   btn_out;
    logic [ENC_W-1:0]       enc_out [ENC_OUTS];
    logic [1:0]             nib_sel;
    t_close_act             close_act;

    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign rx_acc     = i_rx_valid && o_rx_ready;
    assign res_load   = rx_acc && r_in_frame && (i_rx_byte == CH_QUERY);

    assign is_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign digit    = is_digit ? 4'(i_rx_byte - CH_ZERO) : NIB_BAD;
    assign nib_sel  = 2'(r_token.length - 3'd1);

    cfp_token_close #(
        .NUM_BUTTONS  (NUM_BUTTONS),
        .NUM_ENCODERS (NUM_ENCODERS)
    ) u_token_close (
        .i_token (r_token),
        .o_act   (close_act)
    );

    always_comb begin
        case (r_position)
            POS_HUND: digit_weighted = ACC_W'(digit) * ACC_W'(100);
            POS_TENS: digit_weighted = ACC_W'(digit) * ACC_W'(10);
            default:  digit_weighted = ACC_W'(digit);
        endcase
    end

    // result view of the current frame
    assign angle_signed = r_negative ? ANGLE_W'(-{1'b0, r_angle_acc})
                                     : {1'b0, r_angle_acc};

    generate
        for (genvar b = 0; b < BTN_OUT_W; b++) begin : g_btn_out
            if (b < NUM_BUTTONS) begin : g_on
                assign btn_out[b] = r_btn_mask[b];
            end else begin : g_off
                assign btn_out[b] = 1'b0;
            end
        end
        for (genvar e = 0; e < ENC_OUTS; e++) begin : g_enc_out
            if (e < NUM_ENCODERS) begin : g_on
                assign enc_out[e] = r_enc[e];
            end else begin : g_off
                assign enc_out[e] = '0;
            end
        end
    endgenerate

    always_comb begin
        n_in_frame  = r_in_frame;
        n_position  = r_position;
        n_negative  = r_negative;
        n_angle_acc = r_angle_acc;
        n_tok_open  = r_tok_open;
        n_token     = r_token;
        n_btn_mask  = r_btn_mask;
        n_enc       = r_enc;
        n_cfg_flag  = r_cfg_flag;

        if (rx_acc) begin
            if (i_rx_byte == CH_START || (r_in_frame && i_rx_byte == CH_QUERY)) begin
                // restart or close: drop the open token and clear the frame
                n_in_frame  = (i_rx_byte == CH_START);
                n_position  = (i_rx_byte == CH_START) ? POS_SIGN : POS_IDLE;
                n_negative  = 1'b0;
                n_angle_acc = '0;
                n_tok_open  = 1'b0;
                n_token     = '0;
                n_btn_mask  = '0;
                for (int i = 0; i < NUM_ENCODERS; i++) begin
                    n_enc[i] = '0;
                end
            end else if (r_in_frame) begin
                if (r_position == POS_SIGN) begin
                    n_negative = (i_rx_byte == CH_DASH);
                end else if (r_position >= POS_HUND && r_position <= POS_ONES
                             && is_digit) begin
                    n_angle_acc = r_angle_acc + digit_weighted;
                end

                if (r_position >= POS_ONES) begin
                    if (i_rx_byte == CH_DASH) begin
                        if (r_tok_open) begin
                            for (int i = 0; i < NUM_BUTTONS; i++) begin
                                if (close_act.btn_en && close_act.btn_idx == 7'(i)) begin
                                    n_btn_mask[i] = 1'b1;
                                end
                            end
                            for (int i = 0; i < NUM_ENCODERS; i++) begin
                                if (close_act.enc_en && close_act.enc_idx == 4'(i)) begin
                                    n_enc[i] = close_act.enc_val;
                                end
                            end
                            if (close_act.cfg_en) begin
                                n_cfg_flag = 1'b1;
                            end
                        end
                        n_tok_open = 1'b1;
                        n_token    = '0;
                    end else if (r_tok_open && r_position == POS_BODY) begin
                        if (r_token.length == 3'd0) begin
                            case (i_rx_byte)
                                CH_BUTTON: n_token.kind = TOK_BUTTON;
                                CH_ENC:    n_token.kind = TOK_ENC;
                                CH_CONFIG: n_token.kind = TOK_CONFIG;
                                default:   n_token.kind = TOK_OTHER;
                            endcase
                        end else if (r_token.length <= 3'd4) begin
                            for (int k = 0; k < 4; k++) begin
                                if (nib_sel == 2'(k)) begin
                                    n_token.digits[4*k +: 4] = digit;
                                end
                            end
                        end
                        if (r_token.length != LEN_MAX) begin
                            n_token.length = r_token.length + 3'd1;
                        end
                    end
                end

                if (r_position != POS_BODY) begin
                    n_position = r_position + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_position  <= POS_IDLE;
            r_negative  <= 1'b0;
            r_angle_acc <= '0;
            r_tok_open  <= 1'b0;
            r_token     <= '0;
            r_btn_mask  <= '0;
            r_cfg_flag  <= 1'b0;
            r_res_valid <= 1'b0;
            for (int i = 0; i < NUM_ENCODERS; i++) begin
                r_enc[i] <= '0;
            end
        end else begin
            r_in_frame  <= n_in_frame;
            r_position  <= n_position;
            r_negative  <= n_negative;
            r_angle_acc <= n_angle_acc;
            r_tok_open  <= n_tok_open;
            r_token     <= n_token;
            r_btn_mask  <= n_btn_mask;
            r_cfg_flag  <= n_cfg_flag;
            r_enc       <= n_enc;
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // result payload: load on a closing '?'
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res_angle   <= angle_signed;
            r_res_buttons <= btn_out;
            r_res_enc     <= enc_out;
            r_res_cfg     <= r_cfg_flag;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_angle       = $signed(r_res_angle);
    assign o_buttons     = r_res_buttons;
    assign o_encoder_0   = r_res_enc[0];
    assign o_encoder_1   = r_res_enc[1];
    assign o_encoder_2   = r_res_enc[2];
    assign o_encoder_3   = r_res_enc[3];
    assign o_encoder_4   = r_res_enc[4];
    assign o_encoder_5   = r_res_enc[5];
    assign o_config_seen = r_res_cfg;

`ifndef ASSERT_OFF
    a_query_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> o_res_valid)
        else $error("closing item did not produce a result");

    a_idle_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_position == POS_IDLE && !r_tok_open))
        else $error("frame state left over outside a frame");

    a_token_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok_open |-> (r_position == POS_BODY))
        else $error("token open before the frame body");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_angle_acc <= ACC_W'(999))
        else $error("angle accumulator out of range");
`endif

endmodule
